// ===== src/etp_pkg.sv =====
// Shared types and constants for the elapsed-time counter pool.
// Command and slot status codes, per-slot control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package etp_pkg;

  // Default slot count and mode, slot and counter widths
  localparam int unsigned NumTimersDef = 8;
  localparam int unsigned ModeW        = 3;
  localparam int unsigned SlotW        = 3;
  localparam int unsigned CountW       = 32;
  // Slots reachable through the slot field
  localparam int unsigned SlotSpan     = 8;

  typedef enum logic [ModeW-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_START   = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_RESTART = 3'd5,
    CMD_READ    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_STOPPED = 2'd1,
    ST_RUNNING = 2'd2
  } status_e;

  // Update strobes into one slot
  typedef struct packed {
    logic tick;
    logic claim;
    logic free;
    logic run;
    logic halt;
    logic clear;
  } slot_cmd_t;

  // Status seen from one slot
  typedef struct packed {
    logic claimed;
    logic running;
  } slot_stat_t;

endpackage

`default_nettype wire

// ===== src/etp_slot.sv =====
// One timer slot: status register and 32-bit elapsed counter.
// Depends on etp_pkg for the strobe and status structs.
`timescale 1ns / 1ps
`default_nettype none

module etp_slot import etp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slot_cmd_t         cmd_i,
  output slot_stat_t             stat_o,
  output logic [CountW-1:0]      count_o
);

  status_e             status_q, status_d;
  logic [CountW-1:0]   count_q, count_d;

  // Next status: release wins, then claim, run and halt
  always_comb begin
    status_d = status_q;
    if (cmd_i.free) begin
      status_d = ST_FREE;
    end else if (cmd_i.claim) begin
      status_d = ST_STOPPED;
    end else if (cmd_i.run) begin
      status_d = ST_RUNNING;
    end else if (cmd_i.halt) begin
      status_d = ST_STOPPED;
    end
  end

  // Clear on stop or restart, advance on tick while running; wraps at 2^32
  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.tick && (status_q == ST_RUNNING)) begin
      count_d = count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_FREE;
      count_q  <= '0;
    end else begin
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  assign stat_o.claimed = (status_q == ST_STOPPED) || (status_q == ST_RUNNING);
  assign stat_o.running = (status_q == ST_RUNNING);
  assign count_o        = count_q;

endmodule

`default_nettype wire

// ===== src/elapsed_timer_pool.sv =====
// Top level of the elapsed-time counter pool: input register, command decode,
// result register and the bank of timer slots. Depends on etp_pkg, etp_slot.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+---------------------------
//   in      | to pool   | in_valid_i / in_ready_o | mode_i, slot_i
//   out     | from pool | out_valid_o / out_ready_i | ok_o, slot_out_o, elapsed_o
//
// One word per cycle sustained while results are taken; each word passes through the
// input register, then the result register, with combinational decode between.
// Slot state is updated when a word moves from the input register to the result
// register, so words act on the pool strictly in order.
// Reset frees every slot and zeroes every counter at once; words accepted next cycle.
// A stalled result holds; in_ready_o falls only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module elapsed_timer_pool import etp_pkg::*; #(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic [SlotW-1:0]  slot_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   ok_o,
  output logic [SlotW-1:0]       slot_out_o,
  output logic [CountW-1:0]      elapsed_o
);

  localparam int unsigned Span  = (NUM_TIMERS < SlotSpan) ? NUM_TIMERS : SlotSpan;
  localparam int unsigned SpanW = (Span > 1) ? $clog2(Span) : 1;

  // Input register
  logic              in_valid_q;
  logic [ModeW-1:0]  mode_q;
  logic [SlotW-1:0]  slot_q;

  // Result register
  logic              out_valid_q;
  logic              ok_q;
  logic [SlotW-1:0]  slot_out_q;
  logic [CountW-1:0] elapsed_q;

  logic out_free;
  logic adv;

  // Slot bank views
  slot_cmd_t         slot_cmd   [NUM_TIMERS];
  slot_stat_t        slot_stat  [NUM_TIMERS];
  logic [CountW-1:0] slot_cnt   [NUM_TIMERS];
  logic              claimed_lo [Span];
  logic [CountW-1:0] cnt_lo     [Span];

  // Decode results
  logic              slot_ok;
  logic [SpanW-1:0]  sel;
  logic              sel_claimed;
  logic [CountW-1:0] sel_cnt;
  logic              found;
  logic [SlotW-1:0]  alloc_idx;
  logic              res_ok;
  logic [SlotW-1:0]  res_slot;
  logic [CountW-1:0] res_elapsed;
  logic              do_tick, do_alloc, do_free, do_run, do_halt, do_clear;

  // Handshake: result register frees when empty or taken
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      slot_q <= slot_i;
    end
  end

  // Slot bank
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_slot
    logic hit;
    logic claim_hit;
    if (g < Span) begin : g_addr
      assign hit             = (slot_q == SlotW'(g));
      assign claim_hit       = (alloc_idx == SlotW'(g));
      assign claimed_lo[g]   = slot_stat[g].claimed;
      assign cnt_lo[g]       = slot_cnt[g];
    end else begin : g_hidden
      assign hit       = 1'b0;
      assign claim_hit = 1'b0;
    end

    assign slot_cmd[g].tick  = adv && do_tick;
    assign slot_cmd[g].claim = adv && do_alloc && claim_hit;
    assign slot_cmd[g].free  = adv && do_free && hit;
    assign slot_cmd[g].run   = adv && do_run && hit;
    assign slot_cmd[g].halt  = adv && do_halt && hit;
    assign slot_cmd[g].clear = adv && do_clear && hit;

    etp_slot u_slot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (slot_cmd[g]),
      .stat_o  (slot_stat[g]),
      .count_o (slot_cnt[g])
    );
  end

  // Addressed slot; out-of-range slots are gated off
  assign slot_ok     = (32'(slot_q) < NUM_TIMERS);
  assign sel         = SpanW'(slot_q);
  assign sel_claimed = slot_ok && claimed_lo[sel];
  assign sel_cnt     = slot_ok ? cnt_lo[sel] : '0;

  // Lowest free slot among those the slot field reaches
  always_comb begin
    found     = 1'b0;
    alloc_idx = '0;
    for (int unsigned i = 0; i < Span; i++) begin
      if (!found && !claimed_lo[i]) begin
        found     = 1'b1;
        alloc_idx = SlotW'(i);
      end
    end
  end

  // Command decode
  always_comb begin
    res_ok      = 1'b1;
    res_slot    = slot_q;
    res_elapsed = '0;
    do_tick     = 1'b0;
    do_alloc    = 1'b0;
    do_free     = 1'b0;
    do_run      = 1'b0;
    do_halt     = 1'b0;
    do_clear    = 1'b0;
    case (cmd_e'(mode_q))
      CMD_TICK: begin
        do_tick = 1'b1;
      end
      CMD_ALLOC: begin
        res_ok   = found;
        res_slot = found ? alloc_idx : '0;
        do_alloc = found;
      end
      CMD_RELEASE: begin
        do_free = slot_ok;
      end
      CMD_START: begin
        do_run = sel_claimed;
      end
      CMD_STOP: begin
        if (sel_claimed) begin
          res_elapsed = sel_cnt;
          do_halt     = 1'b1;
          do_clear    = 1'b1;
        end
      end
      CMD_RESTART: begin
        if (sel_claimed) begin
          res_elapsed = sel_cnt;
          do_run      = 1'b1;
          do_clear    = 1'b1;
        end
      end
      CMD_READ: begin
        res_elapsed = sel_cnt;
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q       <= res_ok;
      slot_out_q <= res_slot;
      elapsed_q  <= res_elapsed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign slot_out_o  = slot_out_q;
  assign elapsed_o   = elapsed_q;

endmodule

`default_nettype wire

// ===== src/etp_checker.sv =====
// Port-level checks for the elapsed-time counter pool, bound to the top level.
// Depends on etp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module etp_checker import etp_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              ok_o,
  input wire logic [SlotW-1:0]  slot_out_o,
  input wire logic [CountW-1:0] elapsed_o
);

  logic [1:0] occ_q, occ_d;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Track words inside the pool
  always_comb begin
    occ_d = occ_q + 2'(in_fire) - 2'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o) &&
      $stable(slot_out_o) && $stable(elapsed_o))
    else $error("result changed while stalled");

  // A failed allocate carries nothing else
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> (slot_out_o == '0) && (elapsed_o == '0))
    else $error("failed allocate with non-zero fields");

  // Never more than two words in flight
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q != 2'd3)
    else $error("more than two words held");

  // No result without a word inside
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != 2'd0)
    else $error("result shown with no word held");

  // Full pool with a stalled result pushes back
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == 2'd2) && !out_ready_i |-> !in_ready_o)
    else $error("ready while both registers full and result stalled");

endmodule

bind elapsed_timer_pool etp_checker u_etp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .ok_o        (ok_o),
  .slot_out_o  (slot_out_o),
  .elapsed_o   (elapsed_o)
);

`default_nettype wire
